// ===== rtl/sit_pkg.sv =====
// Shared constants and types for the segment intersection test block.
package sit_pkg;

  // Default coordinate width, in bits.
  localparam int COORD_BITS_DEFAULT = 16;

  // Register stages from an input transfer to the result register.
  localparam int SIT_STAGES = 6;

  // Per-stage load enables and valid bits of the pipeline.
  typedef struct packed {
    logic [SIT_STAGES-1:0] en;
    logic [SIT_STAGES-1:0] vld;
  } pipe_ctrl_t;

endpackage

// ===== rtl/sit_in_if.sv =====
// Input channel: valid/ready handshake with two 2D segments as payload.
interface sit_in_if #(
  parameter int COORD_BITS = sit_pkg::COORD_BITS_DEFAULT
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] first_start_x;
  logic signed [COORD_BITS-1:0] first_start_y;
  logic signed [COORD_BITS-1:0] first_end_x;
  logic signed [COORD_BITS-1:0] first_end_y;
  logic signed [COORD_BITS-1:0] second_start_x;
  logic signed [COORD_BITS-1:0] second_start_y;
  logic signed [COORD_BITS-1:0] second_end_x;
  logic signed [COORD_BITS-1:0] second_end_y;

  modport source (
    output valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    input  ready
  );

  modport sink (
    input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    output ready
  );
endinterface

// ===== rtl/sit_out_if.sv =====
// Output channel: valid/ready handshake with the intersection flag.
interface sit_out_if;
  logic valid;
  logic ready;
  logic intersects;

  modport source (output valid, intersects, input ready);
  modport sink   (input valid, intersects, output ready);
endinterface

// ===== rtl/sit_pipe_ctrl.sv =====
// Pipeline flow control: per-stage valid bits and load enables with bubble removal.
module sit_pipe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                out_ready,
  output logic                in_ready,
  output sit_pkg::pipe_ctrl_t ctrl
);

  localparam int N = sit_pkg::SIT_STAGES;

  logic [N-1:0] vld;
  logic [N-1:0] en;

  // A stage may load when it is empty or the stage after it moves on
  always_comb begin
    en[N-1] = !vld[N-1] || out_ready;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  // Valid bits follow the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < N; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_ready = en[0];
  assign ctrl.en  = en;
  assign ctrl.vld = vld;

endmodule

// ===== rtl/segment_intersection_test.sv =====
// Top level: pipelined exact 2D segment intersection test.
//
//  channel  | dir | handshake   | payload
//  ---------+-----+-------------+-------------------------------------------
//  seg_in   | in  | valid/ready | A, B, C, D as signed COORD_BITS coords
//  result   | out | valid/ready | intersects (1 bit)
//
// One transfer per cycle unless result stalls with every stage full. The six
// register stages: differences, products, cross/dot sums, ratio tests,
// interval ends, final select. rst (synchronous) clears all valid bits. A
// stall on result backs up stage by stage; empty stages keep filling, so
// seg_in stays ready until every stage holds an item.
module segment_intersection_test #(
  parameter int COORD_BITS = sit_pkg::COORD_BITS_DEFAULT
) (
  input logic      clk,
  input logic      rst,
  sit_in_if.sink   seg_in,
  sit_out_if.source result
);

  localparam int N  = sit_pkg::SIT_STAGES;
  localparam int D  = COORD_BITS + 1;  // coordinate differences
  localparam int P  = 2 * D;           // products
  localparam int W  = P + 1;           // cross and dot products
  localparam int W1 = W + 1;           // projected endpoint of C->D

  sit_pkg::pipe_ctrl_t ctrl;

  sit_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (seg_in.valid),
    .out_ready (result.ready),
    .in_ready  (seg_in.ready),
    .ctrl      (ctrl)
  );

  // True when 0 <= num/den <= 1 for a nonzero den
  function automatic logic ratio_ok(input logic signed [W-1:0] num,
                                    input logic signed [W-1:0] den);
    logic res;
    if (!den[W-1]) begin
      res = !num[W-1] && (num <= den);
    end else begin
      res = (num[W-1] || (num == '0)) && (num >= den);
    end
    return res;
  endfunction

  // Stage 0: r = B-A, s = D-C, q = C-A
  logic signed [D-1:0] rx, ry, sx, sy, qx, qy;

  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      rx <= D'(seg_in.first_end_x)   - D'(seg_in.first_start_x);
      ry <= D'(seg_in.first_end_y)   - D'(seg_in.first_start_y);
      sx <= D'(seg_in.second_end_x)  - D'(seg_in.second_start_x);
      sy <= D'(seg_in.second_end_y)  - D'(seg_in.second_start_y);
      qx <= D'(seg_in.second_start_x) - D'(seg_in.first_start_x);
      qy <= D'(seg_in.second_start_y) - D'(seg_in.first_start_y);
    end
  end

  // Stage 1: all partial products
  logic signed [P-1:0] m_rx_sy, m_ry_sx;  // r x s
  logic signed [P-1:0] m_qx_ry, m_qy_rx;  // q x r
  logic signed [P-1:0] m_qx_sy, m_qy_sx;  // q x s
  logic signed [P-1:0] m_rx_rx, m_ry_ry;  // r . r
  logic signed [P-1:0] m_qx_rx, m_qy_ry;  // q . r
  logic signed [P-1:0] m_sx_rx, m_sy_ry;  // s . r

  always_ff @(posedge clk) begin
    if (ctrl.en[1]) begin
      m_rx_sy <= rx * sy;
      m_ry_sx <= ry * sx;
      m_qx_ry <= qx * ry;
      m_qy_rx <= qy * rx;
      m_qx_sy <= qx * sy;
      m_qy_sx <= qy * sx;
      m_rx_rx <= rx * rx;
      m_ry_ry <= ry * ry;
      m_qx_rx <= qx * rx;
      m_qy_ry <= qy * ry;
      m_sx_rx <= sx * rx;
      m_sy_ry <= sy * ry;
    end
  end

  // Stage 2: cross and dot products
  logic signed [W-1:0] rxs, qxr, qxs, len, p0, sdr;

  always_ff @(posedge clk) begin
    if (ctrl.en[2]) begin
      rxs <= W'(m_rx_sy) - W'(m_ry_sx);
      qxr <= W'(m_qx_ry) - W'(m_qy_rx);
      qxs <= W'(m_qx_sy) - W'(m_qy_sx);
      len <= W'(m_rx_rx) + W'(m_ry_ry);
      p0  <= W'(m_qx_rx) + W'(m_qy_ry);
      sdr <= W'(m_sx_rx) + W'(m_sy_ry);
    end
  end

  // Stage 3: parameter range tests, zero tests, far end of C->D on A->B
  logic                 t_ok_3, u_ok_3, rxs_zero_3, qxr_zero_3, len_zero_3;
  logic signed [W1-1:0] p0_3, p1_3;
  logic signed [W-1:0]  len_3;

  always_ff @(posedge clk) begin
    if (ctrl.en[3]) begin
      t_ok_3     <= ratio_ok(qxs, rxs);
      u_ok_3     <= ratio_ok(qxr, rxs);
      rxs_zero_3 <= (rxs == '0);
      qxr_zero_3 <= (qxr == '0);
      len_zero_3 <= (len == '0);
      p0_3       <= W1'(p0);
      p1_3       <= W1'(p0) + W1'(sdr);
      len_3      <= len;
    end
  end

  // Stage 4: order the projected interval; fold the non-collinear cases
  logic                 cross_hit_4, collinear_4;
  logic signed [W1-1:0] lo_4, hi_4;
  logic signed [W-1:0]  len_4;

  always_ff @(posedge clk) begin
    if (ctrl.en[4]) begin
      cross_hit_4 <= !rxs_zero_3 && t_ok_3 && u_ok_3;
      collinear_4 <= rxs_zero_3 && qxr_zero_3 && !len_zero_3;
      if (p0_3 < p1_3) begin
        lo_4 <= p0_3;
        hi_4 <= p1_3;
      end else begin
        lo_4 <= p1_3;
        hi_4 <= p0_3;
      end
      len_4 <= len_3;
    end
  end

  // Stage 5: clip interval to [0, len] and test overlap
  logic signed [W1-1:0] len_ext, lo_clip, hi_clip;
  logic                 overlap;
  logic                 intersects_q;

  always_comb begin
    len_ext = W1'(len_4);
    lo_clip = lo_4[W1-1] ? '0 : lo_4;
    hi_clip = (hi_4 > len_ext) ? len_ext : hi_4;
    overlap = (lo_clip <= hi_clip);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[5]) begin
      intersects_q <= cross_hit_4 || (collinear_4 && overlap);
    end
  end

  assign result.valid      = ctrl.vld[N-1];
  assign result.intersects = intersects_q;

endmodule

// ===== rtl/sit_checker.sv =====
// Port-level checker for the segment intersection test, bound to the top level.
module sit_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic intersects
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its flag
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(intersects))
    else $error("result flag changed while stalled");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

  // Input backpressure only when the output is stalled and the pipe is full
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without an output stall");

endmodule

bind segment_intersection_test sit_checker u_sit_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (seg_in.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .intersects (result.intersects)
);

// ===== sim/tb_top.sv =====
// Testbench for the segment intersection test block: directed and random segment pairs.
`timescale 1ns / 100ps

module tb_top;

  localparam int COORD_BITS     = sit_pkg::COORD_BITS_DEFAULT;
  localparam int RANDOM_PAIRS   = 1800;
  localparam int CALM_FIRST     = 800;   // window of transfers with no idling on either side
  localparam int CALM_LAST      = 1100;
  localparam int MID_DRAIN_AT   = 1300;
  localparam int IDLE_PERCENT   = 38;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS    = 10;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // Two segments: A->B and C->D
  typedef struct {
    coord_t ax, ay, bx, by, cx, cy, dx, dy;
  } seg_pair_t;

  typedef struct {
    bit        touch;
    seg_pair_t pair;
  } touch_entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sit_in_if #(.COORD_BITS(COORD_BITS)) seg_if ();
  sit_out_if res_if ();

  segment_intersection_test #(.COORD_BITS(COORD_BITS)) DUT (
    .clk    (clk),
    .rst    (rst),
    .seg_in (seg_if),
    .result (res_if)
  );

  always #4 clk = ~clk;

  seg_pair_t    pair_queue[$];      // pairs waiting to be driven
  touch_entry_t touch_expected[$];  // predicted flags of accepted pairs, oldest first
  seg_pair_t    drive_item;
  touch_entry_t touch_head;
  bit           send_now;
  int           directed_count;
  int           total_pairs;
  int           launched_count = 0;
  int           checked_count  = 0;
  int           error_count    = 0;
  int           stall_cycles   = 0;

  // t = (q x s)/rxs or u = (q x r)/rxs lies in [0,1], without a division
  function automatic bit param_in_unit(longint num, longint den);
    if (den > 0) return num >= 0 && num <= den;
    return num <= 0 && num >= den;
  endfunction

  // Exact intersection flag of two segments; all products fit in 64 bits
  function automatic bit calc_intersects(seg_pair_t p);
    longint rx, ry, sx, sy, qx, qy, rxs, qxr, qxs, len_sq, proj_c, proj_d, lo, hi;
    rx  = longint'(p.bx) - longint'(p.ax);
    ry  = longint'(p.by) - longint'(p.ay);
    sx  = longint'(p.dx) - longint'(p.cx);
    sy  = longint'(p.dy) - longint'(p.cy);
    qx  = longint'(p.cx) - longint'(p.ax);
    qy  = longint'(p.cy) - longint'(p.ay);
    rxs = rx * sy - ry * sx;
    qxr = qx * ry - qy * rx;
    qxs = qx * sy - qy * sx;
    if (rxs != 0) return param_in_unit(qxs, rxs) && param_in_unit(qxr, rxs);
    // parallel: off the line never touches, a point-sized first segment never does
    if (qxr != 0) return 1'b0;
    len_sq = rx * rx + ry * ry;
    if (len_sq == 0) return 1'b0;
    // collinear: overlap of C and D projected onto A->B with [0, |r|^2]
    proj_c = qx * rx + qy * ry;
    proj_d = proj_c + sx * rx + sy * ry;
    lo = (proj_c < proj_d) ? proj_c : proj_d;
    hi = (proj_c < proj_d) ? proj_d : proj_c;
    if (lo < 0) lo = 0;
    if (hi > len_sq) hi = len_sq;
    return lo <= hi;
  endfunction

  function automatic int srange(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int corner_coord();
    int picks[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    return picks[$urandom_range(0, 6)];
  endfunction

  task automatic queue_pair(int ax, int ay, int bx, int by, int cx, int cy, int dx, int dy);
    seg_pair_t p;
    p.ax = coord_t'(ax); p.ay = coord_t'(ay); p.bx = coord_t'(bx); p.by = coord_t'(by);
    p.cx = coord_t'(cx); p.cy = coord_t'(cy); p.dx = coord_t'(dx); p.dy = coord_t'(dy);
    pair_queue.push_back(p);
  endtask

  // Driver: launches queued pairs, holds off at drain points until all results are in
  always @(posedge clk) begin
    if (rst) begin
      seg_if.valid          <= 1'b0;
      seg_if.first_start_x  <= '0;
      seg_if.first_start_y  <= '0;
      seg_if.first_end_x    <= '0;
      seg_if.first_end_y    <= '0;
      seg_if.second_start_x <= '0;
      seg_if.second_start_y <= '0;
      seg_if.second_end_x   <= '0;
      seg_if.second_end_y   <= '0;
    end else begin
      if (seg_if.valid && seg_if.ready) begin
        touch_expected.push_back('{calc_intersects(drive_item), drive_item});
      end
      if (!seg_if.valid || seg_if.ready) begin
        send_now = pair_queue.size() > 0 &&
                   ((launched_count >= CALM_FIRST && launched_count < CALM_LAST) ||
                    $urandom_range(0, 99) >= IDLE_PERCENT);
        if ((launched_count == directed_count || launched_count == MID_DRAIN_AT) &&
            checked_count != launched_count)
          send_now = 1'b0;
        if (send_now) begin
          drive_item = pair_queue.pop_front();
          seg_if.valid          <= 1'b1;
          seg_if.first_start_x  <= drive_item.ax;
          seg_if.first_start_y  <= drive_item.ay;
          seg_if.first_end_x    <= drive_item.bx;
          seg_if.first_end_y    <= drive_item.by;
          seg_if.second_start_x <= drive_item.cx;
          seg_if.second_start_y <= drive_item.cy;
          seg_if.second_end_x   <= drive_item.dx;
          seg_if.second_end_y   <= drive_item.dy;
          launched_count        <= launched_count + 1;
        end else begin
          seg_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (touch_expected.size() == 0) begin
          if (error_count < MAX_REPORTS)
            $display("unexpected result: intersects=%b", res_if.intersects);
          error_count <= error_count + 1;
        end else begin
          touch_head = touch_expected.pop_front();
          checked_count <= checked_count + 1;
          if (res_if.intersects !== touch_head.touch) begin
            if (error_count < MAX_REPORTS)
              $display("mismatch on result %0d: A(%0d,%0d) B(%0d,%0d) C(%0d,%0d) D(%0d,%0d)",
                       checked_count, touch_head.pair.ax, touch_head.pair.ay,
                       touch_head.pair.bx, touch_head.pair.by, touch_head.pair.cx,
                       touch_head.pair.cy, touch_head.pair.dx, touch_head.pair.dy);
            if (error_count < MAX_REPORTS)
              $display("  intersects expected %b, got %b", touch_head.touch, res_if.intersects);
            error_count <= error_count + 1;
          end
        end
      end
      res_if.ready <= (checked_count >= CALM_FIRST && checked_count < CALM_LAST) ||
                      $urandom_range(0, 99) >= IDLE_PERCENT;
    end
  end

  // Watchdog: ends the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (seg_if.valid && seg_if.ready) || (res_if.valid && res_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", stall_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Stimulus and end of run
  initial begin
    int kind, px, py, ux, uy, kb, kc, kd, ox, oy, n;

    // directed: extremes, endpoint contact, parallel, collinear and point segments
    queue_pair(0, 0, 0, 0, 0, 0, 0, 0);
    queue_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    queue_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    queue_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    queue_pair(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767);
    queue_pair(0, 0, 10, 0, 0, 1, 10, 1);
    queue_pair(0, -5, 0, 5, 1, -5, 1, 5);
    queue_pair(0, 0, 10, 0, 5, 0, 20, 0);
    queue_pair(0, 0, 10, 0, 11, 0, 20, 0);
    queue_pair(0, 0, 10, 0, 10, 0, 20, 0);
    queue_pair(0, 0, 10, 0, 30, 0, -5, 0);
    queue_pair(0, 0, 10, 0, -7, 0, -1, 0);
    queue_pair(5, 5, 5, 5, 0, 0, 10, 10);
    queue_pair(3, -4, 3, -4, 3, -4, 3, -4);
    queue_pair(0, 0, 10, 10, 5, 5, 5, 5);
    queue_pair(0, 0, 10, 10, 5, 6, 5, 6);
    queue_pair(0, 0, 10, 0, 5, 0, 5, 10);
    queue_pair(0, 0, 10, 0, 10, 0, 10, 10);
    queue_pair(0, 0, 10, 0, 5, 1, 5, 10);
    queue_pair(-32768, 0, 32767, 0, 32767, 0, -32768, 0);
    queue_pair(-32768, -32768, 32767, 32767, 0, 0, 1, 1);
    queue_pair(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768);
    directed_count = pair_queue.size();

    // random: a mix of free pairs and constructed near-degenerate geometry
    for (n = 0; n < RANDOM_PAIRS; n++) begin
      kind = $urandom_range(0, 9);
      px = srange(-20000, 20000);
      py = srange(-20000, 20000);
      ux = srange(-50, 50);
      uy = srange(-50, 50);
      kb = srange(-4, 4);
      kc = srange(-4, 4);
      kd = srange(-4, 4);
      ox = srange(-3, 3);
      oy = srange(-3, 3);
      case (kind)
        0, 1, 2: begin
          queue_pair($urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom);
        end
        3: begin
          queue_pair(srange(-8, 7), srange(-8, 7), srange(-8, 7), srange(-8, 7),
                     srange(-8, 7), srange(-8, 7), srange(-8, 7), srange(-8, 7));
        end
        4, 5: begin
          queue_pair(px, py, px + kb * ux, py + kb * uy,
                     px + kc * ux, py + kc * uy, px + kd * ux, py + kd * uy);
        end
        6: begin
          queue_pair(px, py, px + kb * ux, py + kb * uy, px + kc * ux + ox,
                     py + kc * uy + oy, px + kd * ux + ox, py + kd * uy + oy);
        end
        7: begin
          // second segment starts on an end of the first
          if ($urandom_range(0, 1))
            queue_pair(px, py, ux * 400, uy * 400, px, py, $urandom, $urandom);
          else
            queue_pair(px, py, ux * 400, uy * 400, ux * 400, uy * 400, $urandom, $urandom);
        end
        8: begin
          // one of the segments is a single point
          if ($urandom_range(0, 1))
            queue_pair(ox, oy, ox, oy, srange(-8, 7), srange(-8, 7),
                       srange(-8, 7), srange(-8, 7));
          else
            queue_pair(srange(-8, 7), srange(-8, 7), srange(-8, 7), srange(-8, 7),
                       ox, oy, ox, oy);
        end
        default: begin
          queue_pair(corner_coord(), corner_coord(), corner_coord(), corner_coord(),
                     corner_coord(), corner_coord(), corner_coord(), corner_coord());
        end
      endcase
    end
    total_pairs = pair_queue.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (launched_count != total_pairs || checked_count != total_pairs)
      @(posedge clk);
    repeat (4 * sit_pkg::SIT_STAGES) @(posedge clk);

    if (touch_expected.size() != 0)
      $display("%0d results never arrived", touch_expected.size());
    if (error_count == 0 && touch_expected.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
